FILE: src/dsr_pkg.sv
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Shared constants, codes and types for the scheduler cells and top level.
// ----------------------------------------------------------------------------
package dsr_pkg;

    localparam int MAX_REQUESTS_DEF = 16;
    localparam int TRACK_BITS_DEF   = 16;

    localparam int FIELD_TRACK_W = 16;
    localparam int SEEK_W        = 16;
    localparam int TOTAL_W       = 20;
    localparam int COUNT_OUT_W   = 5;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [SEEK_W-1:0]  SEEK_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_TRACK = 1'd1;

    // Scheduling modes
    localparam logic [1:0] MODE_FCFS  = 2'd0;
    localparam logic [1:0] MODE_SSTF  = 2'd1;
    localparam logic [1:0] MODE_SCAN  = 2'd2;
    localparam logic [1:0] MODE_CSCAN = 2'd3;

    // Request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

FILE: src/dsr_cell.sv
// ----------------------------------------------------------------------------
// Scheduler cell
// Holds one stored track and its served flag; rotates with its neighbor.
// ----------------------------------------------------------------------------
module dsr_cell #(
    parameter int TRACK_BITS = dsr_pkg::TRACK_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsr_pkg::cell_ctl_t    ctl,
    input  logic                  load,
    input  logic [TRACK_BITS-1:0] load_track,
    input  logic [TRACK_BITS-1:0] in_track,
    input  logic                  in_served,
    output logic [TRACK_BITS-1:0] track,
    output logic                  served
);

    logic [TRACK_BITS-1:0] track_reg;
    logic [TRACK_BITS-1:0] track_next;
    logic                  served_reg;
    logic                  served_next;

    always_comb
    begin
        track_next  = track_reg;
        served_next = served_reg;
        if (load)
        begin
            track_next  = load_track;
            served_next = 1'b0;
        end
        else if (ctl.clear)
        begin
            served_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            track_next  = in_track;
            served_next = in_served;
        end
    end

    always_ff @(posedge clk)
    begin
        track_reg <= track_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= 1'b0;
        end
        else
        begin
            served_reg <= served_next;
        end
    end

    assign track  = track_reg;
    assign served = served_reg;

endmodule

FILE: src/disk_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// Disk request scheduler, top level
// A load request is taken only while idle. A run with n stored requests
// gives n results: each result needs one full rotation of the cell ring
// past the head comparator. Results are strobed for one cycle; the
// receiver cannot stall. Reset clears the state, count, flags and config;
// stored tracks and result values are undefined until written.
// ----------------------------------------------------------------------------
module disk_request_scheduler_top #(
    parameter int MAX_REQUESTS = dsr_pkg::MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = dsr_pkg::TRACK_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [dsr_pkg::FIELD_TRACK_W-1:0]   track,
    input  logic                                cfg_we,
    input  logic [dsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dsr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                strobe,
    output logic [dsr_pkg::FIELD_TRACK_W-1:0]   served_track,
    output logic [dsr_pkg::SEEK_W-1:0]          seek_distance,
    output logic [dsr_pkg::TOTAL_W-1:0]         total_distance,
    output logic [dsr_pkg::COUNT_OUT_W-1:0]     request_count,
    output logic                                overflowed,
    output logic                                last
);

    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int STEP_W = $clog2(MAX_REQUESTS);
    localparam int SUM_W  = 33;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_REQUESTS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_REQUESTS);

    // Cell ring
    logic [TRACK_BITS-1:0] cell_trk [MAX_REQUESTS];
    logic                  cell_srv [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] load_sel;
    dsr_pkg::cell_ctl_t    ctl;
    logic                  mark_hit;
    logic [TRACK_BITS-1:0] load_trk;

    // Control and datapath registers
    dsr_pkg::state_t       state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic                  drop_reg, drop_next;
    logic [1:0]            mode_reg, mode_next;
    logic [dsr_pkg::CFG_DATA_W-1:0] start_reg, start_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;
    logic [dsr_pkg::TOTAL_W-1:0] sum_reg, sum_next;
    logic                  mark_pend_reg, mark_pend_next;
    logic [STEP_W-1:0]     mark_idx_reg, mark_idx_next;

    logic                  best_f_reg, best_f_next;
    logic [TRACK_BITS-1:0] best_trk_reg, best_trk_next;
    logic [TRACK_BITS-1:0] best_d_reg, best_d_next;
    logic [STEP_W-1:0]     best_idx_reg, best_idx_next;
    logic                  up_f_reg, up_f_next;
    logic [TRACK_BITS-1:0] up_trk_reg, up_trk_next;
    logic [STEP_W-1:0]     up_idx_reg, up_idx_next;
    logic                  oth_f_reg, oth_f_next;
    logic [TRACK_BITS-1:0] oth_trk_reg, oth_trk_next;
    logic [STEP_W-1:0]     oth_idx_reg, oth_idx_next;

    // Result registers
    logic                  strobe_reg, strobe_next;
    logic [dsr_pkg::FIELD_TRACK_W-1:0] out_trk_reg, out_trk_next;
    logic [dsr_pkg::SEEK_W-1:0]  out_seek_reg, out_seek_next;
    logic [dsr_pkg::TOTAL_W-1:0] out_sum_reg, out_sum_next;
    logic [dsr_pkg::COUNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                  out_ovf_reg, out_ovf_next;
    logic                  out_last_reg, out_last_next;

    // Head-of-ring compare terms
    logic [TRACK_BITS-1:0] h_trk;
    logic                  eligible;
    logic [TRACK_BITS-1:0] h_dist;
    logic [TRACK_BITS-1:0] start_trk;

    // Emit terms
    logic [TRACK_BITS-1:0] sel_trk;
    logic [STEP_W-1:0]     sel_idx;
    logic [TRACK_BITS-1:0] sel_dist;
    logic [SUM_W-1:0]      sum_wide;

    logic accept_load;
    logic accept_run;

    assign accept_load = start && !busy && (kind == dsr_pkg::KIND_LOAD);
    assign accept_run  = start && !busy && (kind == dsr_pkg::KIND_RUN);
    assign load_trk    = TRACK_BITS'(track);
    assign start_trk   = TRACK_BITS'(start_reg);

    assign h_trk    = cell_trk[0];
    assign mark_hit = mark_pend_reg && (step_reg == mark_idx_reg);
    assign eligible = (CNT_W'(step_reg) < count_reg) && !cell_srv[0] && !mark_hit;
    assign h_dist   = (h_trk >= head_reg) ? (h_trk - head_reg) : (head_reg - h_trk);

    assign ctl.shift = (state_reg == dsr_pkg::ST_SEARCH);
    assign ctl.clear = accept_run;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REQUESTS; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % MAX_REQUESTS;

            assign load_sel[gi] = accept_load && (count_reg == CNT_W'(gi));

            dsr_cell #(
                .TRACK_BITS (TRACK_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .load       (load_sel[gi]),
                .load_track (load_trk),
                .in_track   (cell_trk[NXT]),
                .in_served  ((gi == MAX_REQUESTS - 1) ? (cell_srv[NXT] | mark_hit)
                                                      : cell_srv[NXT]),
                .track      (cell_trk[gi]),
                .served     (cell_srv[gi])
            );
        end
    endgenerate

    // Pick the winner of the finished pass
    always_comb
    begin
        sel_trk = best_trk_reg;
        sel_idx = best_idx_reg;
        if ((mode_reg == dsr_pkg::MODE_SCAN) || (mode_reg == dsr_pkg::MODE_CSCAN))
        begin
            if (up_f_reg)
            begin
                sel_trk = up_trk_reg;
                sel_idx = up_idx_reg;
            end
            else
            begin
                sel_trk = oth_trk_reg;
                sel_idx = oth_idx_reg;
            end
        end
    end

    assign sel_dist = (sel_trk >= head_reg) ? (sel_trk - head_reg) : (head_reg - sel_trk);
    assign sum_wide = SUM_W'(sum_reg) + SUM_W'(sel_dist);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsr_pkg::ST_IDLE:
            begin
                if (accept_run && (count_reg != '0))
                begin
                    state_next = dsr_pkg::ST_SEARCH;
                end
            end
            dsr_pkg::ST_SEARCH:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = dsr_pkg::ST_EMIT;
                end
            end
            dsr_pkg::ST_EMIT:
            begin
                if ((k_reg + CNT_W'(1)) == count_reg)
                begin
                    state_next = dsr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = dsr_pkg::ST_SEARCH;
                end
            end
            default:
            begin
                state_next = dsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        step_next      = step_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        drop_next      = drop_reg;
        mode_next      = mode_reg;
        start_next     = start_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        mark_pend_next = mark_pend_reg;
        mark_idx_next  = mark_idx_reg;
        best_f_next    = best_f_reg;
        best_trk_next  = best_trk_reg;
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        up_f_next      = up_f_reg;
        up_trk_next    = up_trk_reg;
        up_idx_next    = up_idx_reg;
        oth_f_next     = oth_f_reg;
        oth_trk_next   = oth_trk_reg;
        oth_idx_next   = oth_idx_reg;
        strobe_next    = 1'b0;
        out_trk_next   = out_trk_reg;
        out_seek_next  = out_seek_reg;
        out_sum_next   = out_sum_reg;
        out_cnt_next   = out_cnt_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                dsr_pkg::REG_MODE:        mode_next  = cfg_data[1:0];
                dsr_pkg::REG_START_TRACK: start_next = cfg_data;
                default:                  mode_next  = mode_reg;
            endcase
        end

        unique case (state_reg)
            dsr_pkg::ST_IDLE:
            begin
                if (accept_load)
                begin
                    if (count_reg < CNT_FULL)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                else if (accept_run)
                begin
                    if (count_reg == '0)
                    begin
                        drop_next = 1'b0;
                    end
                    head_next      = start_trk;
                    sum_next       = '0;
                    k_next         = '0;
                    step_next      = '0;
                    mark_pend_next = 1'b0;
                    best_f_next    = 1'b0;
                    up_f_next      = 1'b0;
                    oth_f_next     = 1'b0;
                end
            end
            dsr_pkg::ST_SEARCH:
            begin
                step_next = (step_reg == STEP_LAST) ? '0 : step_reg + STEP_W'(1);
                if (mode_reg == dsr_pkg::MODE_FCFS)
                begin
                    if (CNT_W'(step_reg) == k_reg)
                    begin
                        best_f_next   = 1'b1;
                        best_trk_next = h_trk;
                        best_idx_next = step_reg;
                    end
                end
                else if (mode_reg == dsr_pkg::MODE_SSTF)
                begin
                    // later entry wins a tie
                    if (eligible && (!best_f_reg || (h_dist <= best_d_reg)))
                    begin
                        best_f_next   = 1'b1;
                        best_trk_next = h_trk;
                        best_d_next   = h_dist;
                        best_idx_next = step_reg;
                    end
                end
                else
                begin
                    if (eligible && (h_trk > start_trk) && (!up_f_reg || (h_trk < up_trk_reg)))
                    begin
                        up_f_next   = 1'b1;
                        up_trk_next = h_trk;
                        up_idx_next = step_reg;
                    end
                    if (eligible && (!oth_f_reg ||
                        ((mode_reg == dsr_pkg::MODE_SCAN) ? (h_trk > oth_trk_reg)
                                                          : (h_trk < oth_trk_reg))))
                    begin
                        oth_f_next   = 1'b1;
                        oth_trk_next = h_trk;
                        oth_idx_next = step_reg;
                    end
                end
                // previous pick got its served flag on this pass
                if (step_reg == STEP_LAST)
                begin
                    mark_pend_next = 1'b0;
                end
            end
            dsr_pkg::ST_EMIT:
            begin
                strobe_next   = 1'b1;
                out_trk_next  = dsr_pkg::FIELD_TRACK_W'(sel_trk);
                out_seek_next = (32'(sel_dist) > 32'(dsr_pkg::SEEK_MAX)) ?
                                dsr_pkg::SEEK_MAX : dsr_pkg::SEEK_W'(sel_dist);
                sum_next      = (sum_wide > SUM_W'(dsr_pkg::TOTAL_MAX)) ?
                                dsr_pkg::TOTAL_MAX : dsr_pkg::TOTAL_W'(sum_wide);
                out_sum_next  = sum_next;
                out_cnt_next  = dsr_pkg::COUNT_OUT_W'(count_reg);
                out_ovf_next  = drop_reg;
                out_last_next = ((k_reg + CNT_W'(1)) == count_reg);
                head_next     = sel_trk;
                k_next        = k_reg + CNT_W'(1);
                mark_pend_next = 1'b1;
                mark_idx_next  = sel_idx;
                best_f_next    = 1'b0;
                up_f_next      = 1'b0;
                oth_f_next     = 1'b0;
                step_next      = '0;
                if ((k_reg + CNT_W'(1)) == count_reg)
                begin
                    // run done: empty the store
                    count_next     = '0;
                    drop_next      = 1'b0;
                    mark_pend_next = 1'b0;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsr_pkg::ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            drop_reg      <= 1'b0;
            mode_reg      <= dsr_pkg::MODE_FCFS;
            start_reg     <= '0;
            head_reg      <= '0;
            sum_reg       <= '0;
            mark_pend_reg <= 1'b0;
            mark_idx_reg  <= '0;
            best_f_reg    <= 1'b0;
            up_f_reg      <= 1'b0;
            oth_f_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            drop_reg      <= drop_next;
            mode_reg      <= mode_next;
            start_reg     <= start_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
            mark_pend_reg <= mark_pend_next;
            mark_idx_reg  <= mark_idx_next;
            best_f_reg    <= best_f_next;
            up_f_reg      <= up_f_next;
            oth_f_reg     <= oth_f_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_trk_reg <= best_trk_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        up_trk_reg   <= up_trk_next;
        up_idx_reg   <= up_idx_next;
        oth_trk_reg  <= oth_trk_next;
        oth_idx_reg  <= oth_idx_next;
        out_trk_reg  <= out_trk_next;
        out_seek_reg <= out_seek_next;
        out_sum_reg  <= out_sum_next;
        out_cnt_reg  <= out_cnt_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign busy           = (state_reg != dsr_pkg::ST_IDLE);
    assign strobe         = strobe_reg;
    assign served_track   = out_trk_reg;
    assign seek_distance  = out_seek_reg;
    assign total_distance = out_sum_reg;
    assign request_count  = out_cnt_reg;
    assign overflowed     = out_ovf_reg;
    assign last           = out_last_reg;

endmodule
